### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked in the cycle after every clock edge that sees reset asserted.
`define ASSERT_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) \
    else $error(msg);

`endif

### rtl/core/csp_pkg.sv
// Shared constants, types and helpers of the cubic spline evaluator.
package csp_pkg;

  localparam int SEGMENTS = 64;
  localparam int SEG_W    = $clog2(SEGMENTS);
  localparam int POWERS   = 4;
  localparam int COEF_W   = 32;
  localparam int DIST_W   = 24;
  localparam int REG_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = DIST_W + REG_W;
  localparam int IDXLEN_W = SEG_W + REG_W;
  // Offset, square and cube widths hold for tables of up to 256 segments,
  // where |offset| stays below 2^24.
  localparam int T_W      = DIST_W + 2;
  localparam int TT_W     = 2 * T_W;
  localparam int T2_W     = 2 * DIST_W - FRAC_W;
  localparam int SUM_W    = 64;
  localparam int OUT_W    = 32;

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int REG_ADDR_LSB = 2;

  localparam logic [REG_W-1:0] DENSITY_RST = 16'd766;
  localparam logic [REG_W-1:0] SEG_LEN_RST = 16'd21889;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_EVAL  = 1'b1
  } func_t;

  typedef enum logic {
    REG_DENSITY    = 1'b0,
    REG_SEG_LENGTH = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                     func;
    logic [5:0]               coef_segment;
    logic                     coef_axis;
    logic [1:0]               coef_power;
    logic signed [COEF_W-1:0] coef_value;
    logic [DIST_W-1:0]        arc_distance;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic signed [OUT_W-1:0] rate_x;
    logic signed [OUT_W-1:0] rate_y;
    logic                    out_of_range;
  } out_item_t;

  // One memory row: the four coefficients of one axis of one segment.
  typedef logic [POWERS-1:0][COEF_W-1:0] coef_row_t;

  // Lookup stage to evaluation pipeline.
  typedef struct packed {
    logic                  valid;
    logic                  out_of_range;
    logic signed [T_W-1:0] offset;
  } off_info_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    logic signed [OUT_W-1:0] res;
    hi_lim = {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    lo_lim = {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    if (v > hi_lim) begin
      res = hi_lim[OUT_W-1:0];
    end else if (v < lo_lim) begin
      res = lo_lim[OUT_W-1:0];
    end else begin
      res = v[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/csp_ram.sv
// Generic single-clock RAM with bit write mask and registered read.
module csp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [WIDTH-1:0]         wmask,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask[i]) begin
          mem_r[waddr][i] <= wdata[i];
        end
      end
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/csp_front.sv
// Input stage, segment index and offset, and the coefficient memories.
`include "assert_macros.svh"

module csp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  csp_pkg::in_item_t   in_data,
  input  logic [15:0]         density,
  input  logic [15:0]         seg_length,
  input  logic                down_ready,
  output csp_pkg::off_info_t  off_info,
  output csp_pkg::coef_row_t  coef_x,
  output csp_pkg::coef_row_t  coef_y
);
  import csp_pkg::*;

  logic                  en1, en2;
  logic                  v1_r, v2_r;
  in_item_t              item_r;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  is_eval, is_write, seg_ok, wr_go;
  logic [REG_W-1:0]      idx_raw;
  logic                  over;
  logic [SEG_W-1:0]      idx;
  logic [IDXLEN_W-1:0]   idx_len;
  logic signed [T_W-1:0] offset_r, offset_nxt;
  logic                  flag_r;
  logic [SEG_W-1:0]      waddr;
  coef_row_t             wdata_row, wmask_row;

  assign prod_nxt = PROD_W'(in_data.arc_distance) * PROD_W'(density);

  assign is_eval  = (item_r.func == FUNC_EVAL);
  assign is_write = (item_r.func == FUNC_WRITE);
  assign seg_ok   = int'(item_r.coef_segment) < SEGMENTS;
  assign wr_go    = v1_r && is_write && seg_ok;

  // A write item never waits on the evaluation side: it leaves after its
  // memory write. Reads and writes both happen here, in item order.
  assign en2      = !v2_r || down_ready;
  assign en1      = !v1_r || !is_eval || en2;
  assign in_stall = !en1;

  // Product is Q16.24: the integer part is the raw segment index.
  assign idx_raw = prod_r[PROD_W-1:DIST_W];
  assign over    = idx_raw > REG_W'(SEGMENTS - 1);
  assign idx     = over ? SEG_W'(SEGMENTS - 1) : idx_raw[SEG_W-1:0];
  assign idx_len = IDXLEN_W'(idx) * IDXLEN_W'(seg_length);

  assign offset_nxt = $signed(T_W'(item_r.arc_distance)) - $signed(T_W'(idx_len));

  assign waddr = SEG_W'(item_r.coef_segment);

  always_comb begin
    for (int p = 0; p < POWERS; p++) begin
      wdata_row[p] = item_r.coef_value;
      wmask_row[p] = (item_r.coef_power == 2'(p)) ? '1 : '0;
    end
  end

  csp_ram #(
    .WIDTH($bits(coef_row_t)),
    .DEPTH(SEGMENTS)
  ) u_ram_x (
    .clk   (clk),
    .we    (wr_go && !item_r.coef_axis),
    .waddr (waddr),
    .wdata (wdata_row),
    .wmask (wmask_row),
    .re    (en2),
    .raddr (idx),
    .rdata (coef_x)
  );

  csp_ram #(
    .WIDTH($bits(coef_row_t)),
    .DEPTH(SEGMENTS)
  ) u_ram_y (
    .clk   (clk),
    .we    (wr_go && item_r.coef_axis),
    .waddr (waddr),
    .wdata (wdata_row),
    .wmask (wmask_row),
    .re    (en2),
    .raddr (idx),
    .rdata (coef_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r && is_eval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item_r <= in_data;
      prod_r <= prod_nxt;
    end
    if (en2) begin
      offset_r <= offset_nxt;
      flag_r   <= over;
    end
  end

  assign off_info.valid        = v2_r;
  assign off_info.out_of_range = flag_r;
  assign off_info.offset       = offset_r;

  `ASSERT_RESET(a_front_clear, !v1_r && !v2_r, "front stages not empty after reset")
  `ASSERT_SYNC(a_offset_range, v2_r |-> (offset_r[T_W-1] == offset_r[T_W-2]),
               "segment offset outside its range")

endmodule

### rtl/core/csp_eval.sv
// Polynomial and derivative pipeline for both axes, with the output register.
`include "assert_macros.svh"

module csp_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  csp_pkg::off_info_t  off_info,
  input  csp_pkg::coef_row_t  coef_x,
  input  csp_pkg::coef_row_t  coef_y,
  output logic                down_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output csp_pkg::out_item_t  out_data
);
  import csp_pkg::*;

  localparam int P1_W    = COEF_W + T_W;
  localparam int Q2_W    = COEF_W + 1 + T_W;
  localparam int P2_W    = COEF_W + T2_W + 1;
  localparam int Q3_W    = COEF_W + 2 + T2_W + 1;
  localparam int PT3_W   = T2_W + 1 + T_W;
  localparam int T3_W    = PT3_W - FRAC_W;
  localparam int SPLIT_W = 24;
  localparam int LO_W    = COEF_W + SPLIT_W + 1;
  localparam int HI_W    = COEF_W + T3_W - SPLIT_W;
  localparam int P3_W    = HI_W + SPLIT_W;
  localparam int TERM3_W = P3_W - FRAC_W;

  logic en3, en4, en5, en6, en7;
  logic v3_r, v4_r, v5_r, v6_r, v7_r;
  logic flag3_r, flag4_r, flag5_r, flag6_r;

  coef_row_t                   coef_in [2];

  // Stage 3: offset square and first-order products
  logic signed [T_W-1:0]       off3_r;
  logic signed [TT_W-1:0]      tt_r, tt_nxt;
  logic signed [COEF_W-1:0]    c0_r [2];
  logic signed [COEF_W-1:0]    c1_r [2];
  logic signed [COEF_W-1:0]    c2_r [2];
  logic signed [COEF_W-1:0]    c3_r [2];
  logic signed [P1_W-1:0]      p1_r [2];
  logic signed [P1_W-1:0]      p1_nxt [2];
  logic signed [Q2_W-1:0]      q2_r [2];
  logic signed [Q2_W-1:0]      q2_nxt [2];

  // Stage 4: cube product and second-order products
  logic [T2_W-1:0]             t2;
  logic signed [T2_W:0]        t2s;
  logic signed [PT3_W-1:0]     pt3_r, pt3_nxt;
  logic signed [COEF_W+1:0]    c3x3 [2];
  logic signed [COEF_W-1:0]    c3d_r [2];
  logic signed [P2_W-1:0]      p2_r [2];
  logic signed [P2_W-1:0]      p2_nxt [2];
  logic signed [Q3_W-1:0]      q3_r [2];
  logic signed [Q3_W-1:0]      q3_nxt [2];
  logic signed [SUM_W-1:0]     sp4_r [2];
  logic signed [SUM_W-1:0]     sp4_nxt [2];
  logic signed [SUM_W-1:0]     sr4_r [2];
  logic signed [SUM_W-1:0]     sr4_nxt [2];

  // Stage 5: cubic term as two partial products
  logic signed [T3_W-1:0]      t3;
  logic signed [SPLIT_W:0]     t3_lo;
  logic signed [T3_W-SPLIT_W-1:0] t3_hi;
  logic signed [LO_W-1:0]      lo_r [2];
  logic signed [LO_W-1:0]      lo_nxt [2];
  logic signed [HI_W-1:0]      hi_r [2];
  logic signed [HI_W-1:0]      hi_nxt [2];
  logic signed [SUM_W-1:0]     sp5_r [2];
  logic signed [SUM_W-1:0]     sp5_nxt [2];
  logic signed [SUM_W-1:0]     sr5_r [2];
  logic signed [SUM_W-1:0]     sr5_nxt [2];

  // Stage 6: recombine the cubic term, saturate the derivative
  logic signed [P3_W-1:0]      p3 [2];
  logic signed [TERM3_W-1:0]   term3_r [2];
  logic signed [TERM3_W-1:0]   term3_nxt [2];
  logic signed [SUM_W-1:0]     sp6_r [2];
  logic signed [OUT_W-1:0]     rate6_r [2];
  logic signed [OUT_W-1:0]     rate6_nxt [2];

  out_item_t                   out_r, out_nxt;

  // A stage takes a new item when it is empty or its item moves on.
  assign en7        = !v7_r || !out_stall;
  assign en6        = !v6_r || en7;
  assign en5        = !v5_r || en6;
  assign en4        = !v4_r || en5;
  assign en3        = !v3_r || en4;
  assign down_ready = en3;

  assign coef_in[0] = coef_x;
  assign coef_in[1] = coef_y;

  always_comb begin
    tt_nxt = off_info.offset * off_info.offset;
    for (int a = 0; a < 2; a++) begin
      p1_nxt[a] = $signed(coef_in[a][1]) * off_info.offset;
      q2_nxt[a] = $signed({coef_in[a][2], 1'b0}) * off_info.offset;
    end
  end

  // t2 = floor(t*t / 2^16), never negative
  assign t2      = tt_r[FRAC_W +: T2_W];
  assign t2s     = $signed({1'b0, t2});
  assign pt3_nxt = t2s * off3_r;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      c3x3[a]    = (COEF_W+2)'(c3_r[a]) + ((COEF_W+2)'(c3_r[a]) <<< 1);
      p2_nxt[a]  = c2_r[a] * t2s;
      q3_nxt[a]  = c3x3[a] * t2s;
      sp4_nxt[a] = SUM_W'(c0_r[a]) + SUM_W'(p1_r[a] >>> FRAC_W);
      sr4_nxt[a] = SUM_W'(c1_r[a]) + SUM_W'(q2_r[a] >>> FRAC_W);
    end
  end

  // Split t3 into an unsigned low part and a signed high part.
  assign t3    = T3_W'(pt3_r >>> FRAC_W);
  assign t3_lo = $signed({1'b0, t3[SPLIT_W-1:0]});
  assign t3_hi = $signed(t3[T3_W-1:SPLIT_W]);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      lo_nxt[a]  = c3d_r[a] * t3_lo;
      hi_nxt[a]  = c3d_r[a] * t3_hi;
      sp5_nxt[a] = sp4_r[a] + SUM_W'(p2_r[a] >>> FRAC_W);
      sr5_nxt[a] = sr4_r[a] + SUM_W'(q3_r[a] >>> FRAC_W);
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      p3[a]        = (P3_W'(hi_r[a]) <<< SPLIT_W) + P3_W'(lo_r[a]);
      term3_nxt[a] = TERM3_W'(p3[a] >>> FRAC_W);
      rate6_nxt[a] = sat_out(sr5_r[a]);
    end
  end

  always_comb begin
    out_nxt.pos_x        = sat_out(sp6_r[0] + SUM_W'(term3_r[0]));
    out_nxt.pos_y        = sat_out(sp6_r[1] + SUM_W'(term3_r[1]));
    out_nxt.rate_x       = rate6_r[0];
    out_nxt.rate_y       = rate6_r[1];
    out_nxt.out_of_range = flag6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en3) v3_r <= off_info.valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      flag3_r <= off_info.out_of_range;
      off3_r  <= off_info.offset;
      tt_r    <= tt_nxt;
      for (int a = 0; a < 2; a++) begin
        c0_r[a] <= $signed(coef_in[a][0]);
        c1_r[a] <= $signed(coef_in[a][1]);
        c2_r[a] <= $signed(coef_in[a][2]);
        c3_r[a] <= $signed(coef_in[a][3]);
        p1_r[a] <= p1_nxt[a];
        q2_r[a] <= q2_nxt[a];
      end
    end
    if (en4) begin
      flag4_r <= flag3_r;
      pt3_r   <= pt3_nxt;
      for (int a = 0; a < 2; a++) begin
        c3d_r[a] <= c3_r[a];
        p2_r[a]  <= p2_nxt[a];
        q3_r[a]  <= q3_nxt[a];
        sp4_r[a] <= sp4_nxt[a];
        sr4_r[a] <= sr4_nxt[a];
      end
    end
    if (en5) begin
      flag5_r <= flag4_r;
      for (int a = 0; a < 2; a++) begin
        lo_r[a]  <= lo_nxt[a];
        hi_r[a]  <= hi_nxt[a];
        sp5_r[a] <= sp5_nxt[a];
        sr5_r[a] <= sr5_nxt[a];
      end
    end
    if (en6) begin
      flag6_r <= flag5_r;
      for (int a = 0; a < 2; a++) begin
        term3_r[a] <= term3_nxt[a];
        sp6_r[a]   <= sp5_r[a];
        rate6_r[a] <= rate6_nxt[a];
      end
    end
    if (en7) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v7_r;
  assign out_data  = out_r;

  `ASSERT_SYNC(a_square_fits, v3_r |-> (tt_r[TT_W-1:FRAC_W+T2_W] == '0),
               "offset square exceeds its width")
  `ASSERT_SYNC(a_stage6_hold, v6_r && !en7 |=> v6_r && $stable(sp6_r[0]),
               "stage six item lost while output is held")

endmodule

### rtl/core/cubic_spline_point_and_gradient.sv
// Top level of the cubic spline point and gradient evaluator.
`include "assert_macros.svh"

// Evaluates a piecewise cubic spline in x and y, and its derivative, at an
// arc distance. Write items (func 0) load one Q16.16 coefficient into the
// table; evaluate items (func 1) return pos_x/pos_y and rate_x/rate_y
// saturated to Q16.16, with out_of_range set when the segment index was
// clamped to the last segment. Both kinds of item are accepted one per
// cycle while in_stall is low. A result is presented once its evaluate
// item has passed seven register stages: one for distance times
// density, one for the index clamp, offset and memory read, four
// multiplier stages, and the output register. Write items take effect
// in the second stage, in order with evaluations, so a lookup
// always sees every write accepted before it. The coefficients live in two
// 64 x 128-bit memories (one per axis, one row per segment) and are not
// cleared by reset: load every segment that will be evaluated. Back pressure
// on the result channel fills empty stages first; the input stalls only when
// the pipeline is full. density (Q8.8) sits at byte address 0 and
// segment_length (Q0.16) at 4; write them while no item is in flight.
module cubic_spline_point_and_gradient (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  csp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output csp_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csp_pkg::PADDR_W-1:0]   paddr,
  input  logic [csp_pkg::PDATA_W-1:0]   pwdata,
  output logic [csp_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import csp_pkg::*;

  logic [REG_W-1:0] density_r, density_nxt;
  logic [REG_W-1:0] seg_length_r, seg_length_nxt;
  logic             cfg_wr;
  reg_idx_t         reg_idx;
  off_info_t        off_info;
  coef_row_t        coef_x, coef_y;
  logic             down_ready;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[REG_ADDR_LSB]);

  always_comb begin
    density_nxt    = density_r;
    seg_length_nxt = seg_length_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_DENSITY:    density_nxt    = pwdata[REG_W-1:0];
        REG_SEG_LENGTH: seg_length_nxt = pwdata[REG_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DENSITY:    prdata = PDATA_W'(density_r);
      REG_SEG_LENGTH: prdata = PDATA_W'(seg_length_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      density_r    <= DENSITY_RST;
      seg_length_r <= SEG_LEN_RST;
    end else begin
      density_r    <= density_nxt;
      seg_length_r <= seg_length_nxt;
    end
  end

  csp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .density    (density_r),
    .seg_length (seg_length_r),
    .down_ready (down_ready),
    .off_info   (off_info),
    .coef_x     (coef_x),
    .coef_y     (coef_y)
  );

  csp_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .off_info   (off_info),
    .coef_x     (coef_x),
    .coef_y     (coef_y),
    .down_ready (down_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `ASSERT_SYNC(a_seg_len_write,
               cfg_wr && (reg_idx == REG_SEG_LENGTH) |=> seg_length_r == $past(pwdata[REG_W-1:0]),
               "segment length write not taken")

endmodule
